/* design/pca_pkg.sv */
// ----------------------------------------------------------------------------
// pca_pkg
// Shared widths, codes, the priority table and the controller/datapath
// command and status bundles for the priority claim arbiter.
// ----------------------------------------------------------------------------
package pca_pkg;

  localparam int NUM_CLIENTS_DEF = 7;

  localparam int COMMAND_W = 2;
  localparam int CLIENT_W  = 3;
  localparam int SCENE_W   = 5;
  localparam int PARAM_W   = 7;
  localparam int PRIO_W    = 7;
  localparam int TTL_W     = 16;
  localparam int TIME_W    = 40;

  localparam logic [COMMAND_W-1:0] CMD_TICK    = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_REQUEST = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_RELEASE = 2'd2;

  localparam logic [PARAM_W-1:0] PARAM_MAX = 7'd100;

  localparam logic [SCENE_W-1:0] SCENE_OFF          = 5'd0;
  localparam logic [SCENE_W-1:0] SCENE_BOOT         = 5'd1;
  localparam logic [SCENE_W-1:0] SCENE_OTA_PROGRESS = 5'd11;
  localparam logic [SCENE_W-1:0] SCENE_OTA_APPLYING = 5'd12;
  localparam logic [SCENE_W-1:0] SCENE_ERROR        = 5'd13;

  localparam logic [CLIENT_W-1:0] CLIENT_SYSTEM   = 3'd0;
  localparam logic [CLIENT_W-1:0] CLIENT_NETWORK  = 3'd1;
  localparam logic [CLIENT_W-1:0] CLIENT_BT       = 3'd2;
  localparam logic [CLIENT_W-1:0] CLIENT_AI       = 3'd3;
  localparam logic [CLIENT_W-1:0] CLIENT_OTA      = 3'd4;
  localparam logic [CLIENT_W-1:0] CLIENT_NOTIFY   = 3'd5;
  localparam logic [CLIENT_W-1:0] CLIENT_SETTINGS = 3'd6;

  localparam logic [PRIO_W-1:0] PRIO_ERROR       = 7'd90;
  localparam logic [PRIO_W-1:0] PRIO_OTA         = 7'd100;
  localparam logic [PRIO_W-1:0] PRIO_SYSTEM_BOOT = 7'd50;
  localparam logic [PRIO_W-1:0] PRIO_SYSTEM      = 7'd10;
  localparam logic [PRIO_W-1:0] PRIO_AI          = 7'd80;
  localparam logic [PRIO_W-1:0] PRIO_NETWORK     = 7'd60;
  localparam logic [PRIO_W-1:0] PRIO_BT          = 7'd55;
  localparam logic [PRIO_W-1:0] PRIO_NOTIFY      = 7'd40;
  localparam logic [PRIO_W-1:0] PRIO_SETTINGS    = 7'd45;
  localparam logic [PRIO_W-1:0] PRIO_NONE        = 7'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_last;
    logic out_busy;
  } dp_status_t;

  // Scene rules take precedence over the per-client table.
  function automatic logic [PRIO_W-1:0] prio_of(input logic [CLIENT_W-1:0] who,
                                                input logic [SCENE_W-1:0] scene);
    logic [PRIO_W-1:0] p;
    if (scene == SCENE_ERROR) begin
      p = PRIO_ERROR;
    end else if (scene == SCENE_OTA_PROGRESS || scene == SCENE_OTA_APPLYING) begin
      p = PRIO_OTA;
    end else begin
      case (who)
        CLIENT_OTA:      p = PRIO_OTA;
        CLIENT_SYSTEM:   p = (scene == SCENE_BOOT) ? PRIO_SYSTEM_BOOT : PRIO_SYSTEM;
        CLIENT_AI:       p = PRIO_AI;
        CLIENT_NETWORK:  p = PRIO_NETWORK;
        CLIENT_BT:       p = PRIO_BT;
        CLIENT_NOTIFY:   p = PRIO_NOTIFY;
        CLIENT_SETTINGS: p = PRIO_SETTINGS;
        default:         p = PRIO_NONE;
      endcase
    end
    return p;
  endfunction

endpackage

/* design/pca_req_if.sv */
// ----------------------------------------------------------------------------
// pca_req_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface pca_req_if;
  logic                          valid;
  logic                          ready;
  logic [pca_pkg::COMMAND_W-1:0] command;
  logic [pca_pkg::CLIENT_W-1:0]  client;
  logic [pca_pkg::SCENE_W-1:0]   scene;
  logic [pca_pkg::PARAM_W-1:0]   param;
  logic [pca_pkg::TTL_W-1:0]     ttl_ms;
  logic [pca_pkg::TIME_W-1:0]    time_ms;

  modport source (output valid, command, client, scene, param, ttl_ms, time_ms,
                  input ready);
  modport sink (input valid, command, client, scene, param, ttl_ms, time_ms,
                output ready);
endinterface

/* design/pca_rsp_if.sv */
// ----------------------------------------------------------------------------
// pca_rsp_if
// Grant channel: valid/ready handshake with the grant payload.
// ----------------------------------------------------------------------------
interface pca_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [pca_pkg::CLIENT_W-1:0] winner_client;
  logic [pca_pkg::SCENE_W-1:0]  granted_scene;
  logic [pca_pkg::PARAM_W-1:0]  granted_param;
  logic [pca_pkg::TIME_W-1:0]   anim_start_ms;
  logic                         grant_changed;

  modport source (output valid, winner_client, granted_scene, granted_param,
                  anim_start_ms, grant_changed, input ready);
  modport sink (input valid, winner_client, granted_scene, granted_param,
                anim_start_ms, grant_changed, output ready);
endinterface

/* design/pca_ctrl.sv */
// ----------------------------------------------------------------------------
// pca_ctrl
// Sequencer: takes a transaction, runs the slot scan for a tick and hands
// the grant to the output register.
// ----------------------------------------------------------------------------
module pca_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  pca_pkg::dp_status_t status,
  output pca_pkg::ctrl_cmd_t  cmd
);

  pca_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    req_ready      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.scan_step  = 1'b0;
    cmd.out_load   = 1'b0;
    case (state)
      pca_pkg::ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
        // requests and releases finish in the accept cycle
        if (req_valid && status.is_tick) begin
          cmd.scan_start = 1'b1;
          state_next     = pca_pkg::ST_SCAN;
        end
      end
      pca_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = pca_pkg::ST_LOAD;
        end
      end
      pca_pkg::ST_LOAD: begin
        // hold the grant until the output register frees up
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = pca_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pca_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/pca_dpath.sv */
// ----------------------------------------------------------------------------
// pca_dpath
// Claim slots, expiry check and priority compare for one slot a cycle,
// grant history and the output register.
// ----------------------------------------------------------------------------
module pca_dpath #(
  parameter int NUM_CLIENTS = pca_pkg::NUM_CLIENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  pca_pkg::ctrl_cmd_t            cmd,
  output pca_pkg::dp_status_t           status,
  input  logic [pca_pkg::COMMAND_W-1:0] command,
  input  logic [pca_pkg::CLIENT_W-1:0]  client,
  input  logic [pca_pkg::SCENE_W-1:0]   scene,
  input  logic [pca_pkg::PARAM_W-1:0]   param,
  input  logic [pca_pkg::TTL_W-1:0]     ttl_ms,
  input  logic [pca_pkg::TIME_W-1:0]    time_ms,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [pca_pkg::CLIENT_W-1:0]  winner_client,
  output logic [pca_pkg::SCENE_W-1:0]   granted_scene,
  output logic [pca_pkg::PARAM_W-1:0]   granted_param,
  output logic [pca_pkg::TIME_W-1:0]    anim_start_ms,
  output logic                          grant_changed
);

  localparam int IDX_W  = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int TIME_W = pca_pkg::TIME_W;

  logic                         slot_active   [NUM_CLIENTS];
  logic [pca_pkg::SCENE_W-1:0]  slot_scene    [NUM_CLIENTS];
  logic [pca_pkg::PARAM_W-1:0]  slot_param    [NUM_CLIENTS];
  logic [pca_pkg::PRIO_W-1:0]   slot_priority [NUM_CLIENTS];
  logic [TIME_W-1:0]            slot_expiry   [NUM_CLIENTS];

  logic                         enable;
  logic [TIME_W-1:0]            now;
  logic [IDX_W-1:0]             idx;
  logic                         have;
  logic [IDX_W-1:0]             best;
  logic [pca_pkg::PRIO_W-1:0]   top_prio;
  logic [pca_pkg::CLIENT_W-1:0] prev_client;
  logic [pca_pkg::SCENE_W-1:0]  prev_scene;
  logic [TIME_W-1:0]            anim_start;

  logic                         client_ok;
  logic [IDX_W-1:0]             wr_idx;
  logic                         do_request;
  logic                         do_release;
  logic [TIME_W:0]              expiry_sum;
  logic [TIME_W-1:0]            expiry_new;
  logic                         expired;
  logic                         live;
  logic [pca_pkg::CLIENT_W-1:0] gw;
  logic [pca_pkg::SCENE_W-1:0]  gs;
  logic [pca_pkg::PARAM_W-1:0]  gp;
  logic                         changed;

  assign client_ok  = 32'(client) < NUM_CLIENTS;
  assign wr_idx     = IDX_W'(client);
  assign do_request = cmd.accept && client_ok && (command == pca_pkg::CMD_REQUEST);
  assign do_release = cmd.accept && client_ok && (command == pca_pkg::CMD_RELEASE);

  // saturate the expiry at the top of the time range
  assign expiry_sum = {1'b0, time_ms} + (TIME_W + 1)'(ttl_ms);
  always_comb begin
    if (ttl_ms == '0) begin
      expiry_new = '0;
    end else if (expiry_sum[TIME_W]) begin
      expiry_new = '1;
    end else begin
      expiry_new = expiry_sum[TIME_W-1:0];
    end
  end

  // one slot per scan cycle: drop it if expired, else compare its priority
  assign expired = slot_active[idx] && (slot_expiry[idx] != '0) && (now >= slot_expiry[idx]);
  assign live    = slot_active[idx] && !expired;

  assign status.is_tick   = (command == pca_pkg::CMD_TICK);
  assign status.scan_last = (idx == IDX_W'(NUM_CLIENTS - 1));
  assign status.out_busy  = rsp_valid && !rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        slot_active[i] <= 1'b0;
      end
    end else if (do_request) begin
      slot_active[wr_idx] <= 1'b1;
    end else if (do_release) begin
      slot_active[wr_idx] <= 1'b0;
    end else if (cmd.scan_step && expired) begin
      slot_active[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_request) begin
      slot_scene[wr_idx]    <= scene;
      slot_param[wr_idx]    <= (param > pca_pkg::PARAM_MAX) ? pca_pkg::PARAM_MAX : param;
      slot_priority[wr_idx] <= pca_pkg::prio_of(client, scene);
      slot_expiry[wr_idx]   <= expiry_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
    end else if (cfg_we) begin
      enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      now <= time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      have <= 1'b0;
    end else if (cmd.scan_start) begin
      idx  <= '0;
      have <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!status.scan_last) begin
        idx <= idx + IDX_W'(1);
      end
      // ties go to the higher index
      if (live && (!have || slot_priority[idx] >= top_prio)) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && live && (!have || slot_priority[idx] >= top_prio)) begin
      best     <= idx;
      top_prio <= slot_priority[idx];
    end
  end

  always_comb begin
    gw = pca_pkg::CLIENT_SYSTEM;
    gs = pca_pkg::SCENE_OFF;
    gp = '0;
    if (enable && have) begin
      gw = pca_pkg::CLIENT_W'(best);
      gs = slot_scene[best];
      gp = slot_param[best];
    end
  end

  assign changed = (gw != prev_client) || (gs != prev_scene);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_client <= pca_pkg::CLIENT_SYSTEM;
      prev_scene  <= pca_pkg::SCENE_OFF;
      anim_start  <= '0;
    end else if (cmd.out_load && changed) begin
      prev_client <= gw;
      prev_scene  <= gs;
      anim_start  <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      winner_client <= gw;
      granted_scene <= gs;
      granted_param <= gp;
      anim_start_ms <= changed ? now : anim_start;
      grant_changed <= changed;
    end
  end

endmodule

/* design/priority_claim_arbiter_with_ttl.sv */
// ----------------------------------------------------------------------------
// priority_claim_arbiter_with_ttl
// Per-client claim slots with expiry; while enabled, a tick grants the highest-priority
// live claim and reports the winner, scene, param and animation start time.
// ----------------------------------------------------------------------------
// A request or release transaction is applied in its accept cycle. A tick is
// taken in the accept state, then a single expiry-compare and
// priority-compare unit walks the slots in turn in the scan state, then the
// load state puts the grant into the output register. The grant register
// holds a finished grant while the block takes the next transaction; a
// following tick waits in its load state only if the previous grant has not
// yet been taken. The enable register comes out of reset set and may be
// written whenever no tick is in flight.
module priority_claim_arbiter_with_ttl #(
  parameter int NUM_CLIENTS = pca_pkg::NUM_CLIENTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  pca_req_if.sink   req,
  pca_rsp_if.source rsp
);

  pca_pkg::ctrl_cmd_t  cmd;
  pca_pkg::dp_status_t status;

  pca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pca_dpath #(
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .status        (status),
    .command       (req.command),
    .client        (req.client),
    .scene         (req.scene),
    .param         (req.param),
    .ttl_ms        (req.ttl_ms),
    .time_ms       (req.time_ms),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .winner_client (rsp.winner_client),
    .granted_scene (rsp.granted_scene),
    .granted_param (rsp.granted_param),
    .anim_start_ms (rsp.anim_start_ms),
    .grant_changed (rsp.grant_changed)
  );

  // no transaction is taken while the slots are being walked
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> !req.ready)
    else $error("transaction accepted during slot scan");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |=> cmd.scan_step)
    else $error("tick accepted but scan did not start");

  a_load_into_free_reg: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(rsp.valid && !rsp.ready))
    else $error("grant loaded over an untaken grant");

  a_load_shows_grant: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> rsp.valid)
    else $error("loaded grant not presented");

endmodule

/* bench/pca_grant_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_grant_checker
// Watches the command and grant channels of the claim arbiter. Keeps its own
// copy of the claim slots and the enable register, predicts the grant of each
// accepted tick and compares every grant transaction field by field.
// ----------------------------------------------------------------------------
module pca_grant_checker #(
  parameter int NUM_CLIENTS = pca_pkg::NUM_CLIENTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_wdata,
  pca_req_if   req,
  pca_rsp_if   rsp,
  output int   mismatches,
  output int   grants_pending
);
  import pca_pkg::*;

  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [SCENE_W-1:0]  scene;
    logic [PARAM_W-1:0]  param;
    logic [TIME_W-1:0]   anim_start;
    logic                changed;
  } grant_t;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic                slot_live   [NUM_CLIENTS];
  logic [SCENE_W-1:0]  slot_scene  [NUM_CLIENTS];
  logic [PARAM_W-1:0]  slot_param  [NUM_CLIENTS];
  logic [PRIO_W-1:0]   slot_prio   [NUM_CLIENTS];
  logic [TIME_W-1:0]   slot_expiry [NUM_CLIENTS];
  logic [CLIENT_W-1:0] prev_client;
  logic [SCENE_W-1:0]  prev_scene;
  logic [TIME_W-1:0]   anim_start;
  logic                enabled;
  grant_t              expected_grants[$];

  task automatic log_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [TIME_W-1:0] got,
                             input logic [TIME_W-1:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s: got %0d, expected %0d", field, got, want));
    end
  endtask

  // Scene rules win over the per-client table.
  function automatic logic [PRIO_W-1:0] claim_priority(input logic [CLIENT_W-1:0] who,
                                                       input logic [SCENE_W-1:0] scene);
    if (scene == SCENE_ERROR) return PRIO_ERROR;
    if (scene == SCENE_OTA_PROGRESS || scene == SCENE_OTA_APPLYING) return PRIO_OTA;
    case (who)
      CLIENT_OTA:      return PRIO_OTA;
      CLIENT_SYSTEM:   return (scene == SCENE_BOOT) ? PRIO_SYSTEM_BOOT : PRIO_SYSTEM;
      CLIENT_AI:       return PRIO_AI;
      CLIENT_NETWORK:  return PRIO_NETWORK;
      CLIENT_BT:       return PRIO_BT;
      CLIENT_NOTIFY:   return PRIO_NOTIFY;
      CLIENT_SETTINGS: return PRIO_SETTINGS;
      default:         return PRIO_NONE;
    endcase
  endfunction

  task automatic apply_command();
    logic [TIME_W:0]     sum;
    logic [TIME_W-1:0]   now;
    logic [PRIO_W-1:0]   best;
    logic                found;
    grant_t              g;
    now = req.time_ms;
    case (req.command)
      CMD_REQUEST: begin
        if (req.client < NUM_CLIENTS) begin
          slot_live[req.client]  = 1'b1;
          slot_scene[req.client] = req.scene;
          slot_param[req.client] = (req.param > PARAM_MAX) ? PARAM_MAX : req.param;
          slot_prio[req.client]  = claim_priority(req.client, req.scene);
          // saturate expiry at the top of the time range
          sum = {1'b0, now} + (TIME_W + 1)'(req.ttl_ms);
          if (req.ttl_ms == '0) begin
            slot_expiry[req.client] = '0;
          end else begin
            slot_expiry[req.client] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          end
        end
      end
      CMD_RELEASE: begin
        if (req.client < NUM_CLIENTS) slot_live[req.client] = 1'b0;
      end
      CMD_TICK: begin
        for (int i = 0; i < NUM_CLIENTS; i++) begin
          if (slot_live[i] && slot_expiry[i] != '0 && now >= slot_expiry[i]) begin
            slot_live[i] = 1'b0;
          end
        end
        g = '0;
        found = 1'b0;
        best = '0;
        if (enabled) begin
          // later index takes equal priority
          for (int i = 0; i < NUM_CLIENTS; i++) begin
            if (slot_live[i] && (!found || slot_prio[i] >= best)) begin
              found = 1'b1;
              best = slot_prio[i];
              g.client = CLIENT_W'(i);
              g.scene = slot_scene[i];
              g.param = slot_param[i];
            end
          end
        end
        if (g.client != prev_client || g.scene != prev_scene) begin
          prev_client = g.client;
          prev_scene = g.scene;
          anim_start = now;
          g.changed = 1'b1;
        end
        g.anim_start = anim_start;
        expected_grants.push_back(g);
      end
      default: ;
    endcase
  endtask

  task automatic check_grant();
    grant_t want;
    if (expected_grants.size() == 0) begin
      log_mismatch("grant transaction with no tick waiting for it");
      return;
    end
    want = expected_grants.pop_front();
    check_field("winner_client", rsp.winner_client, want.client);
    check_field("granted_scene", rsp.granted_scene, want.scene);
    check_field("granted_param", rsp.granted_param, want.param);
    check_field("anim_start_ms", rsp.anim_start_ms, want.anim_start);
    check_field("grant_changed", rsp.grant_changed, want.changed);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLIENTS; i++) begin
        slot_live[i] = 1'b0;
        slot_scene[i] = '0;
        slot_param[i] = '0;
        slot_prio[i] = '0;
        slot_expiry[i] = '0;
      end
      prev_client = '0;
      prev_scene = '0;
      anim_start = '0;
      enabled = 1'b1;
      expected_grants.delete();
    end else begin
      // compare before pushing so a stray grant cannot match a fresh tick
      if (rsp.valid && rsp.ready) check_grant();
      if (req.valid && req.ready) apply_command();
      if (cfg_we) enabled = cfg_wdata;
    end
    grants_pending <= expected_grants.size();
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives command transactions into the claim arbiter: a directed pass over
// priorities, ties, expiry, saturation and ignored commands, then random
// claim traffic under several enable settings and idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import pca_pkg::*;

  localparam int SETTLE = 2 * (NUM_CLIENTS_DEF + 2) + 4;
  localparam logic [TIME_W-1:0]    TIME_MAX    = '1;
  localparam logic [COMMAND_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int SEGMENTS = 5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  int   mismatches;
  int   grants_pending;
  int   send_idle_pct = 38;
  int   stall_pct = 53;

  int   seg_send   [SEGMENTS] = '{38, 53, 53, 0, 0};
  int   seg_stall  [SEGMENTS] = '{53, 38, 38, 0, 0};
  int   seg_items  [SEGMENTS] = '{400, 150, 300, 100, 350};
  logic seg_enable [SEGMENTS] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  pca_req_if req ();
  pca_rsp_if rsp ();

  priority_claim_arbiter_with_ttl u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  pca_grant_checker u_chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .req            (req),
    .rsp            (rsp),
    .mismatches     (mismatches),
    .grants_pending (grants_pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send(input logic [COMMAND_W-1:0] cmd, input logic [CLIENT_W-1:0] who,
                      input logic [SCENE_W-1:0] scene, input logic [PARAM_W-1:0] param,
                      input logic [TTL_W-1:0] ttl, input logic [TIME_W-1:0] t);
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.client  <= who;
    req.scene   <= scene;
    req.param   <= param;
    req.ttl_ms  <= ttl;
    req.time_ms <= t;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic idle(input int cycles);
    req.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every predicted grant has been taken.
  task automatic wait_grants();
    req.valid <= 1'b0;
    @(posedge clk);
    wait (grants_pending == 0);
    @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    wait_grants();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0]   now_ms;
    logic [COMMAND_W-1:0] cmd;
    logic [CLIENT_W-1:0] who;
    logic [SCENE_W-1:0]  scene;
    logic [TTL_W-1:0]    ttl;
    int                  roll;
    int                  done;

    req.valid   <= 1'b0;
    req.command <= CMD_TICK;
    req.client  <= CLIENT_SYSTEM;
    req.scene   <= SCENE_OFF;
    req.param   <= '0;
    req.ttl_ms  <= '0;
    req.time_ms <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_enable(1'b1);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, 1000);
    send(CMD_REQUEST, CLIENT_SYSTEM, SCENE_BOOT, 0, 0, 1000);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, 1010);
    send(CMD_REQUEST, CLIENT_OTA, 5'd5, 7'd127, 16'd50, 1020);
    send(CMD_REQUEST, CLIENT_AI, SCENE_ERROR, 7'd100, 0, 1020);
    // ota scene lifts the bt client to the ota client's priority
    send(CMD_REQUEST, CLIENT_BT, SCENE_OTA_PROGRESS, 7'd101, 0, 1020);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, 1030);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, 1070);
    send(CMD_REQUEST, 3'd7, SCENE_OTA_APPLYING, 7'd100, 0, 1070);
    send(CMD_RELEASE, 3'd7, SCENE_OFF, 0, 0, 1070);
    send(CMD_UNKNOWN, CLIENT_BT, SCENE_ERROR, 7'd1, 16'd1, 1070);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, 1080);
    send(CMD_RELEASE, CLIENT_BT, 5'd31, 7'd127, 16'hFFFF, TIME_MAX);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, 1090);
    send(CMD_REQUEST, CLIENT_NETWORK, 5'd31, 7'd64, 16'd1, 1100);
    send(CMD_REQUEST, CLIENT_NOTIFY, 5'd16, 7'd1, 16'hFFFF, TIME_MAX - 10);
    send(CMD_REQUEST, CLIENT_SETTINGS, SCENE_OTA_APPLYING, 7'd99, 16'd2, 1100);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, 1100);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, 900);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, 1102);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, TIME_MAX);
    send(CMD_RELEASE, CLIENT_AI, SCENE_OFF, 0, 0, TIME_MAX);
    send(CMD_RELEASE, CLIENT_SYSTEM, SCENE_OFF, 0, 0, TIME_MAX);
    send(CMD_TICK, CLIENT_SYSTEM, SCENE_OFF, 0, 0, 0);

    now_ms = 40'd2000;
    for (int s = 0; s < SEGMENTS; s++) begin
      write_enable(seg_enable[s]);
      send_idle_pct = seg_send[s];
      stall_pct = seg_stall[s];
      done = 0;
      while (done < seg_items[s]) begin
        if ($urandom_range(99) < send_idle_pct) idle($urandom_range(1, 5));
        if ($urandom_range(79) == 0) wait_grants();

        roll = $urandom_range(99);
        if (roll < 88) now_ms += $urandom_range(60);
        else if (roll < 93) now_ms -= $urandom_range(200);
        else if (roll < 97) now_ms = TIME_W'({$urandom(), $urandom()});
        else now_ms = TIME_MAX - $urandom_range(300);

        roll = $urandom_range(99);
        cmd = (roll < 45) ? CMD_TICK : (roll < 80) ? CMD_REQUEST :
              (roll < 95) ? CMD_RELEASE : CMD_UNKNOWN;
        who = ($urandom_range(9) == 0) ? CLIENT_W'($urandom_range(7)) :
                                         CLIENT_W'($urandom_range(NUM_CLIENTS_DEF - 1));
        case ($urandom_range(7))
          0: scene = SCENE_BOOT;
          1: scene = SCENE_OTA_PROGRESS;
          2: scene = SCENE_OTA_APPLYING;
          3: scene = SCENE_ERROR;
          default: scene = SCENE_W'($urandom_range(31));
        endcase
        roll = $urandom_range(99);
        ttl = (roll < 25) ? '0 : (roll < 75) ? TTL_W'($urandom_range(1, 200)) :
                                               TTL_W'($urandom_range(65535));

        send(cmd, who, scene, PARAM_W'($urandom_range(127)), ttl, now_ms);
        if (cmd != CMD_UNKNOWN && (cmd == CMD_TICK || who < NUM_CLIENTS_DEF)) done++;
      end
    end

    wait_grants();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/pca_pkg.sv
design/pca_req_if.sv
design/pca_rsp_if.sv
design/pca_ctrl.sv
design/pca_dpath.sv
design/priority_claim_arbiter_with_ttl.sv
bench/pca_grant_checker.sv
bench/tb.sv
